FILE: rtl/ilt_pkg.sv
// Package for the IRC line tokenizer: characters, phases, token kinds and the
// descriptor and bundle types shared by the core, the output queue and the checker.
// No dependencies.
package ilt_pkg;

    localparam int ILT_MAX_LINE    = 512;
    localparam int ILT_PARAM_LIMIT = 15;

    localparam int ILT_POS_W   = 10;
    localparam int ILT_IDX_W   = 4;
    localparam int ILT_KIND_W  = 3;
    localparam int ILT_SLOTS   = 4;
    localparam int ILT_CNT_W   = $clog2(ILT_SLOTS + 1);
    localparam int ILT_SLOT_W  = $clog2(ILT_SLOTS);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_PREFIX  = 3'd1,
        PH_COMMAND = 3'd2,
        PH_PSTART  = 3'd3,
        PH_PARAM   = 3'd4,
        PH_TRAIL   = 3'd5
    } t_phase;

    typedef enum logic [ILT_KIND_W-1:0] {
        KIND_NICK  = 3'd0,
        KIND_USER  = 3'd1,
        KIND_HOST  = 3'd2,
        KIND_CMD   = 3'd3,
        KIND_PARAM = 3'd4,
        KIND_TRAIL = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ILT_IDX_W-1:0] idx;
        logic [ILT_POS_W-1:0] start;
        logic [ILT_POS_W-1:0] len;
        logic                 last;
        logic                 trunc;
    } t_desc;

    typedef struct packed {
        t_desc [ILT_SLOTS-1:0] ent;
        logic  [ILT_CNT_W-1:0] cnt;
    } t_bundle;

endpackage

FILE: rtl/ilt_core.sv
// Tokenizer core: line state registers and the descriptor bundle for each byte.
// Depends on ilt_pkg.
module ilt_core #(
    parameter int MAX_LINE    = ilt_pkg::ILT_MAX_LINE,
    parameter int PARAM_LIMIT = ilt_pkg::ILT_PARAM_LIMIT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_data_byte,
    output ilt_pkg::t_bundle o_bundle
);
    import ilt_pkg::*;

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int EW = (PW > ILT_POS_W) ? PW : ILT_POS_W;
    localparam logic [PW-1:0] LIM = PW'(MAX_LINE);
    localparam logic [ILT_IDX_W-1:0] PLIM = ILT_IDX_W'(PARAM_LIMIT);
    localparam logic [ILT_IDX_W-1:0] PCAP = '1;

    t_phase               r_phase, n_phase;
    logic [PW-1:0]        r_pos, n_pos;
    logic [PW-1:0]        r_tb, n_tb;
    logic [PW-1:0]        r_at, n_at;
    logic [PW-1:0]        r_bang, n_bang;
    logic                 r_seen_at, n_seen_at;
    logic                 r_seen_bang, n_seen_bang;
    logic [ILT_IDX_W-1:0] r_pcnt, n_pcnt;
    logic                 r_prev_cr, n_prev_cr;
    logic                 r_ovf, n_ovf;

    logic          is_lf, is_sp, is_colon, sat, trunc, pfull;
    logic [PW-1:0] pos, lf_end, pend;

    t_desc [2:0]          p_ent;
    logic [ILT_CNT_W-1:0] p_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p < LIM) ? p + 1'b1 : LIM;
    endfunction

    function automatic logic [ILT_POS_W-1:0] to_field(input logic [PW-1:0] v);
        logic [EW-1:0] t;
        t = EW'(v);
        return t[ILT_POS_W-1:0];
    endfunction

    function automatic t_desc mk_desc(input t_kind kind, input logic [ILT_IDX_W-1:0] idx,
                                      input logic [PW-1:0] start, input logic [PW-1:0] stop,
                                      input logic tr);
        t_desc d;
        d.kind  = kind;
        d.idx   = idx;
        d.start = to_field(start);
        d.len   = (stop > start) ? to_field(stop - start) : '0;
        d.last  = 1'b0;
        d.trunc = tr;
        return d;
    endfunction

    assign is_lf    = (i_data_byte == CH_LF);
    assign is_sp    = (i_data_byte == CH_SPACE);
    assign is_colon = (i_data_byte == CH_COLON);
    assign sat      = (r_pos >= LIM);
    assign pos      = sat ? LIM : r_pos;
    assign lf_end   = (r_prev_cr && (r_pos != '0)) ? r_pos - 1'b1 : r_pos;
    assign pend     = is_lf ? lf_end : pos;
    assign trunc    = r_ovf | (~is_lf & sat);
    assign pfull    = (r_pcnt >= PLIM);

    // prefix descriptors ending at pend
    always_comb begin
        p_ent = '0;
        p_cnt = '0;
        if (r_seen_at) begin
            if (r_seen_bang) begin
                p_ent[0] = mk_desc(KIND_NICK, '0, r_tb, r_bang, trunc);
                p_ent[1] = mk_desc(KIND_USER, '0, bump(r_bang), r_at, trunc);
                p_ent[2] = mk_desc(KIND_HOST, '0, bump(r_at), pend, trunc);
                p_cnt    = ILT_CNT_W'(3);
            end else begin
                p_ent[0] = mk_desc(KIND_NICK, '0, r_tb, r_at, trunc);
                p_ent[1] = mk_desc(KIND_HOST, '0, bump(r_at), pend, trunc);
                p_cnt    = ILT_CNT_W'(2);
            end
        end else begin
            p_ent[0] = mk_desc(KIND_NICK, '0, r_tb, pend, trunc);
            p_cnt    = ILT_CNT_W'(1);
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_pos       = bump(pos);
        n_tb        = r_tb;
        n_at        = r_at;
        n_bang      = r_bang;
        n_seen_at   = r_seen_at;
        n_seen_bang = r_seen_bang;
        n_pcnt      = r_pcnt;
        n_prev_cr   = (i_data_byte == CH_CR);
        n_ovf       = r_ovf | sat;
        if (is_lf) begin
            n_phase     = PH_START;
            n_pos       = '0;
            n_tb        = '0;
            n_at        = '0;
            n_bang      = '0;
            n_seen_at   = 1'b0;
            n_seen_bang = 1'b0;
            n_pcnt      = '0;
            n_prev_cr   = 1'b0;
            n_ovf       = 1'b0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (is_colon) begin
                        n_tb    = bump(pos);
                        n_phase = PH_PREFIX;
                    end else begin
                        n_tb    = pos;
                        n_phase = is_sp ? PH_PSTART : PH_COMMAND;
                    end
                end
                PH_PREFIX: begin
                    if (i_data_byte == CH_AT && !r_seen_at) begin
                        n_seen_at = 1'b1;
                        n_at      = pos;
                    end else if (i_data_byte == CH_BANG && !r_seen_at && !r_seen_bang) begin
                        n_seen_bang = 1'b1;
                        n_bang      = pos;
                    end else if (is_sp) begin
                        n_tb    = bump(pos);
                        n_phase = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    if (is_sp) n_phase = PH_PSTART;
                end
                PH_PSTART: begin
                    if (is_colon) begin
                        n_tb    = bump(pos);
                        n_phase = PH_TRAIL;
                    end else if (pfull) begin
                        n_tb    = pos;
                        n_phase = PH_TRAIL;
                    end else begin
                        n_tb = pos;
                        if (is_sp) begin
                            n_pcnt  = (r_pcnt < PCAP) ? r_pcnt + 1'b1 : r_pcnt;
                            n_phase = PH_PSTART;
                        end else begin
                            n_phase = PH_PARAM;
                        end
                    end
                end
                PH_PARAM: begin
                    if (is_sp) begin
                        n_pcnt  = (r_pcnt < PCAP) ? r_pcnt + 1'b1 : r_pcnt;
                        n_phase = PH_PSTART;
                    end
                end
                PH_TRAIL: begin
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    // descriptor bundle
    always_comb begin
        logic [ILT_CNT_W-1:0] n;
        logic [ILT_CNT_W-1:0] lst;
        o_bundle = '0;
        n        = '0;
        lst      = '0;
        if (is_lf) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    o_bundle.ent[2:0] = p_ent;
                    n = p_cnt;
                    o_bundle.ent[n[ILT_SLOT_W-1:0]] =
                        mk_desc(KIND_CMD, '0, lf_end, lf_end, trunc);
                end
                PH_START, PH_COMMAND: begin
                    o_bundle.ent[0] = mk_desc(KIND_CMD, '0, r_tb, lf_end, trunc);
                end
                PH_PSTART: begin
                    o_bundle.ent[0] = pfull ?
                        mk_desc(KIND_TRAIL, '0, r_pos, lf_end, trunc) :
                        mk_desc(KIND_PARAM, r_pcnt, r_pos, lf_end, trunc);
                end
                PH_PARAM: begin
                    o_bundle.ent[0] = mk_desc(KIND_PARAM, r_pcnt, r_tb, lf_end, trunc);
                end
                default: begin
                    o_bundle.ent[0] = mk_desc(KIND_TRAIL, '0, r_tb, lf_end, trunc);
                end
            endcase
            n   = n + 1'b1;
            lst = n - 1'b1;
            o_bundle.ent[lst[ILT_SLOT_W-1:0]].last = 1'b1;
        end else if (is_sp) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    o_bundle.ent[2:0] = p_ent;
                    n = p_cnt;
                end
                PH_START: begin
                    o_bundle.ent[0] = mk_desc(KIND_CMD, '0, pos, pos, trunc);
                    n = ILT_CNT_W'(1);
                end
                PH_COMMAND: begin
                    o_bundle.ent[0] = mk_desc(KIND_CMD, '0, r_tb, pos, trunc);
                    n = ILT_CNT_W'(1);
                end
                PH_PSTART: begin
                    if (!pfull) begin
                        o_bundle.ent[0] = mk_desc(KIND_PARAM, r_pcnt, pos, pos, trunc);
                        n = ILT_CNT_W'(1);
                    end
                end
                PH_PARAM: begin
                    o_bundle.ent[0] = mk_desc(KIND_PARAM, r_pcnt, r_tb, pos, trunc);
                    n = ILT_CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        o_bundle.cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_pos       <= '0;
            r_tb        <= '0;
            r_at        <= '0;
            r_bang      <= '0;
            r_seen_at   <= 1'b0;
            r_seen_bang <= 1'b0;
            r_pcnt      <= '0;
            r_prev_cr   <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_tb        <= n_tb;
            r_at        <= n_at;
            r_bang      <= n_bang;
            r_seen_at   <= n_seen_at;
            r_seen_bang <= n_seen_bang;
            r_pcnt      <= n_pcnt;
            r_prev_cr   <= n_prev_cr;
            r_ovf       <= n_ovf;
        end
    end

endmodule

FILE: rtl/ilt_outq.sv
// Output queue: holds one byte's descriptor bundle and hands it out one per transaction.
// Depends on ilt_pkg.
module ilt_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ilt_pkg::t_bundle i_bundle,
    input  logic             i_stall,
    output logic             o_stall,
    output logic             o_valid,
    output ilt_pkg::t_desc   o_desc
);
    import ilt_pkg::*;

    logic [ILT_CNT_W-1:0]  r_cnt, n_cnt;
    t_desc [ILT_SLOTS-1:0] r_ent, n_ent;
    logic                  out_fire;

    assign o_valid  = (r_cnt != '0);
    assign out_fire = o_valid & ~i_stall;
    assign o_stall  = ~((r_cnt == '0) | ((r_cnt == ILT_CNT_W'(1)) & ~i_stall));
    assign o_desc   = r_ent[0];

    always_comb begin
        n_cnt = r_cnt;
        n_ent = r_ent;
        if (i_load) begin
            n_cnt = i_bundle.cnt;
            n_ent = i_bundle.ent;
        end else if (out_fire) begin
            n_cnt = r_cnt - 1'b1;
            for (int k = 0; k < ILT_SLOTS - 1; k++) begin
                n_ent[k] = r_ent[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

FILE: rtl/irc_line_tokenizer.sv
// Top level of the IRC line tokenizer: byte input, descriptor output.
// Depends on ilt_pkg, ilt_core and ilt_outq.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------------
//   input    | i_valid / o_stall  | i_data_byte
//   output   | o_valid / i_stall  | o_token_kind, o_param_index, o_token_start,
//            |                    | o_token_length, o_last_of_line, o_truncated
//
// One byte is taken per cycle while o_stall is low; its descriptors (0 to 4) appear
// from the next cycle, one per cycle while i_stall is low. The next byte waits until
// the last of them is taken, as the four-slot output register drains one entry per
// handshake. Synchronous reset clears the line state and the queue. o_stall follows
// i_stall in the cycle the last pending descriptor is offered.
module irc_line_tokenizer #(
    parameter int MAX_LINE    = ilt_pkg::ILT_MAX_LINE,
    parameter int PARAM_LIMIT = ilt_pkg::ILT_PARAM_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ilt_pkg::ILT_KIND_W-1:0] o_token_kind,
    output logic [ilt_pkg::ILT_IDX_W-1:0]  o_param_index,
    output logic [ilt_pkg::ILT_POS_W-1:0]  o_token_start,
    output logic [ilt_pkg::ILT_POS_W-1:0]  o_token_length,
    output logic                          o_last_of_line,
    output logic                          o_truncated
);
    import ilt_pkg::*;

    logic    in_fire;
    t_bundle bundle;
    t_desc   desc;

    assign in_fire = i_valid & ~o_stall;

    ilt_core #(
        .MAX_LINE    (MAX_LINE),
        .PARAM_LIMIT (PARAM_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_data_byte (i_data_byte),
        .o_bundle    (bundle)
    );

    ilt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_fire),
        .i_bundle (bundle),
        .i_stall  (i_stall),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_desc   (desc)
    );

    assign o_token_kind   = desc.kind;
    assign o_param_index  = desc.idx;
    assign o_token_start  = desc.start;
    assign o_token_length = desc.len;
    assign o_last_of_line = desc.last;
    assign o_truncated    = desc.trunc;

endmodule

FILE: rtl/ilt_checker.sv
// Port-level checks for irc_line_tokenizer, attached by bind.
// Depends on ilt_pkg.
module ilt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [7:0]                    i_data_byte,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ilt_pkg::ILT_KIND_W-1:0] o_token_kind,
    input logic [ilt_pkg::ILT_IDX_W-1:0]  o_param_index,
    input logic [ilt_pkg::ILT_POS_W-1:0]  o_token_start,
    input logic [ilt_pkg::ILT_POS_W-1:0]  o_token_length,
    input logic                          o_last_of_line,
    input logic                          o_truncated
);
    import ilt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending transaction");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_token_start)
            && $stable(o_token_length) && $stable(o_last_of_line)
            && $stable(o_param_index) && $stable(o_truncated))
        else $error("stalled transaction changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte))
        else $error("stalled input transaction changed");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind != KIND_PARAM) |-> (o_param_index == '0))
        else $error("nonzero index on a non-parameter token");

endmodule

bind irc_line_tokenizer ilt_checker u_ilt_checker (.*);
